// ===== sv/bcs_pkg.sv =====
`timescale 1ns / 1ps
package bcs_pkg;

    // Field widths fixed by the register map and the item formats.
    localparam int ROI_W    = 10;
    localparam int BH_W     = 7;
    localparam int NB_W     = 5;
    localparam int THR_W    = 14;
    localparam int PIX_W    = 8;
    localparam int SUM_W    = 14;
    localparam int EDGE_W   = 10;
    localparam int CENTER_W = 9;
    localparam int TOP_W    = 10;
    localparam int BANDNO_W = 4;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    localparam logic [ROI_W-1:0] ROI_WIDTH_RST  = 10'd320;
    localparam logic [BH_W-1:0]  BAND_HEIGHT_RST = 7'd18;
    localparam logic [NB_W-1:0]  NUM_BANDS_RST  = 5'd13;
    localparam logic [THR_W-1:0] THRESHOLD_RST  = 14'd1377;

    typedef enum logic [1:0] {
        REG_ROI_WIDTH   = 2'd0,
        REG_BAND_HEIGHT = 2'd1,
        REG_NUM_BANDS   = 2'd2,
        REG_THRESHOLD   = 2'd3
    } t_reg_idx;

    // Per-item control computed when the pixel is accepted.
    typedef struct packed {
        logic live;
        logic start;
        logic first_row;
        logic last_row;
        logic emit;
        logic last_band;
        logic col_in;
        logic col_ge1;
        logic col_right_ok;
    } t_front;

    // Per-item control when the column sum is final.
    typedef struct packed {
        logic start;
        logic hit_left;
        logic hit_right;
        logic emit;
        logic last_band;
    } t_retire;

endpackage

// ===== sv/bcs_ctrl.sv =====
`timescale 1ns / 1ps
module bcs_ctrl #(
    parameter int CW  = 9,
    parameter int HW  = 6,
    parameter int HXW = 7,
    parameter int BW  = 4,
    parameter int NXW = 5,
    parameter int XW  = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_frame_start,
    input  logic [XW-1:0]                  i_w_eff,
    input  logic [HXW-1:0]                 i_h_eff,
    input  logic [NXW-1:0]                 i_nb_eff,
    output bcs_pkg::t_front                o_front,
    output logic [CW-1:0]                  o_col,
    output logic [bcs_pkg::TOP_W-1:0]      o_top,
    output logic [bcs_pkg::BANDNO_W-1:0]   o_band_no
);
    localparam int TW = bcs_pkg::TOP_W;
    localparam int NW = bcs_pkg::BANDNO_W;

    logic [CW-1:0]     r_col, n_col;
    logic [HW-1:0]     r_row, n_row;
    logic [BW-1:0]     r_band, n_band;
    logic              r_done, n_done;

    logic [CW-1:0]     col;
    logic [HW-1:0]     row;
    logic [BW-1:0]     band;
    logic              done;
    logic [XW:0]       col_p1, col_p2;
    logic [HXW:0]      row_p1;
    logic [NXW:0]      band_p1;
    logic              last_col, last_row, last_band;
    logic [BW+HXW-1:0] top_full;

    always_comb begin
        // A frame start restarts the counters before this pixel is placed.
        col  = i_frame_start ? '0 : r_col;
        row  = i_frame_start ? '0 : r_row;
        band = i_frame_start ? '0 : r_band;
        done = i_frame_start ? 1'b0 : r_done;

        col_p1    = (XW+1)'(col) + (XW+1)'(1);
        col_p2    = col_p1 + (XW+1)'(1);
        row_p1    = (HXW+1)'(row) + (HXW+1)'(1);
        band_p1   = (NXW+1)'(band) + (NXW+1)'(1);
        last_col  = col_p1 >= (XW+1)'(i_w_eff);
        last_row  = row_p1 >= (HXW+1)'(i_h_eff);
        last_band = band_p1 >= (NXW+1)'(i_nb_eff);
        top_full  = (BW+HXW)'(band) * (BW+HXW)'(i_h_eff);

        o_front.live         = !done;
        o_front.start        = i_frame_start;
        o_front.first_row    = (row == '0);
        o_front.last_row     = last_row;
        o_front.emit         = !done && last_col && last_row;
        o_front.last_band    = last_band;
        o_front.col_in       = (XW+1)'(col) < (XW+1)'(i_w_eff);
        o_front.col_ge1      = (col != '0);
        o_front.col_right_ok = col_p2 <= (XW+1)'(i_w_eff);
        o_col                = col;
        o_top                = TW'(top_full);
        o_band_no            = NW'(band);

        n_col  = col;
        n_row  = row;
        n_band = band;
        n_done = done;
        if (!done) begin
            if (!last_col) begin
                n_col = CW'(col_p1);
            end else begin
                n_col = '0;
                if (!last_row) begin
                    n_row = HW'(row_p1);
                end else begin
                    n_row = '0;
                    if (last_band) begin
                        n_band = '0;
                        n_done = 1'b1;
                    end else begin
                        n_band = BW'(band_p1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_band <= '0;
            r_done <= 1'b0;
        end else if (i_accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_band <= n_band;
            r_done <= n_done;
        end
    end

endmodule

// ===== sv/bcs_colsum.sv =====
`timescale 1ns / 1ps
module bcs_colsum #(
    parameter int DEPTH = 512,
    parameter int CW    = 9
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_advance,
    input  bcs_pkg::t_front                i_front,
    input  logic [CW-1:0]                  i_col,
    input  logic [bcs_pkg::PIX_W-1:0]      i_pixel,
    input  logic [bcs_pkg::TOP_W-1:0]      i_top,
    input  logic [bcs_pkg::BANDNO_W-1:0]   i_band_no,
    input  logic [bcs_pkg::THR_W-1:0]      i_threshold,
    output logic                           o_retire_valid,
    output bcs_pkg::t_retire               o_retire,
    output logic [CW-1:0]                  o_col,
    output logic [bcs_pkg::TOP_W-1:0]      o_top,
    output logic [bcs_pkg::BANDNO_W-1:0]   o_band_no,
    output logic                           o_emit_pending
);
    localparam int SW = bcs_pkg::SUM_W;

    logic [SW-1:0]                  mem [DEPTH];
    logic [SW-1:0]                  r_rdata;
    logic                           r_valid;
    bcs_pkg::t_front                r_front;
    logic [CW-1:0]                  r_col;
    logic [bcs_pkg::PIX_W-1:0]      r_pixel;
    logic [bcs_pkg::TOP_W-1:0]      r_top;
    logic [bcs_pkg::BANDNO_W-1:0]   r_band_no;

    logic [SW:0]   sum_raw;
    logic [SW-1:0] sum;
    logic          hit;

    always_comb begin
        sum_raw = (SW+1)'(r_rdata) + (SW+1)'(r_pixel);
        if (r_front.first_row) begin
            sum = SW'(r_pixel);
        end else if (sum_raw[SW]) begin
            sum = bcs_pkg::SUM_MAX;
        end else begin
            sum = sum_raw[SW-1:0];
        end
        hit = r_front.last_row && r_front.col_in && (sum >= i_threshold);

        o_retire_valid     = r_valid && i_advance;
        o_retire.start     = r_front.start;
        o_retire.hit_left  = hit && r_front.col_ge1;
        o_retire.hit_right = hit && r_front.col_right_ok;
        o_retire.emit      = r_front.emit;
        o_retire.last_band = r_front.last_band;
        o_col              = r_col;
        o_top              = r_top;
        o_band_no          = r_band_no;
        o_emit_pending     = r_valid && r_front.emit;
    end

    // Consecutive pixels share a column only when the second one starts a
    // frame, and a first-row item ignores the read data, so the write of one
    // item always lands before any read on that column that is used.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rdata <= mem[i_col];
        end
        if (o_retire_valid) begin
            mem[r_col] <= sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_front   <= i_front;
            r_col     <= i_col;
            r_pixel   <= i_pixel;
            r_top     <= i_top;
            r_band_no <= i_band_no;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= i_front.live;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== sv/bcs_edges.sv =====
`timescale 1ns / 1ps
module bcs_edges #(
    parameter int CW        = 9,
    parameter int XW        = 10,
    parameter int FW        = 5,
    parameter int MIN_FOUND = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_retire_valid,
    input  bcs_pkg::t_retire                     i_retire,
    input  logic [CW-1:0]                        i_col,
    input  logic [bcs_pkg::TOP_W-1:0]            i_top,
    input  logic [bcs_pkg::BANDNO_W-1:0]         i_band_no,
    input  logic [XW-1:0]                        i_w_eff,
    input  logic                                 i_ready,
    output logic                                 o_valid,
    output logic [bcs_pkg::EDGE_W-1:0]           o_left_edge,
    output logic signed [bcs_pkg::EDGE_W-1:0]    o_right_edge,
    output logic                                 o_band_found,
    output logic [bcs_pkg::CENTER_W-1:0]         o_center_x,
    output logic [bcs_pkg::TOP_W-1:0]            o_band_top_y,
    output logic [bcs_pkg::BANDNO_W-1:0]         o_band_number,
    output logic                                 o_last_band,
    output logic                                 o_enough_points
);
    localparam int EW  = bcs_pkg::EDGE_W;
    localparam int CXW = bcs_pkg::CENTER_W;

    logic [CW-1:0]        r_left, n_left;
    logic                 r_left_seen, n_left_seen;
    logic signed [CW:0]   r_right, n_right;
    logic [FW-1:0]        r_found, n_found;
    logic                 r_out_valid;

    logic                 base_seen;
    logic signed [CW:0]   base_right;
    logic [FW-1:0]        base_found;
    logic [XW-1:0]        left_x;
    logic signed [XW:0]   right_x;
    logic [XW:0]          ctr_sum;
    logic                 found;
    logic [CXW-1:0]       center;
    logic                 enough;

    always_comb begin
        base_seen  = i_retire.start ? 1'b0 : r_left_seen;
        base_right = i_retire.start ? '1 : r_right;
        base_found = i_retire.start ? '0 : r_found;

        n_left_seen = base_seen || i_retire.hit_left;
        n_left      = (i_retire.hit_left && !base_seen) ? i_col : r_left;
        n_right     = i_retire.hit_right ? $signed({1'b0, i_col}) : base_right;

        left_x  = n_left_seen ? XW'(n_left) : i_w_eff;
        right_x = (XW+1)'(n_right);
        found   = right_x > $signed({1'b0, left_x});
        ctr_sum = {1'b0, left_x} + $unsigned(right_x);
        center  = found ? CXW'(ctr_sum[XW:1]) : '0;
        n_found = base_found + FW'(found);
        enough  = i_retire.last_band && (32'(n_found) >= MIN_FOUND);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_seen <= 1'b0;
            r_right     <= '1;
            r_found     <= '0;
        end else if (i_retire_valid) begin
            if (i_retire.emit) begin
                r_left_seen <= 1'b0;
                r_right     <= '1;
                r_found     <= i_retire.last_band ? '0 : n_found;
            end else begin
                r_left_seen <= n_left_seen;
                r_right     <= n_right;
                r_found     <= base_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_retire_valid) begin
            r_left <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_retire_valid && i_retire.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_retire_valid && i_retire.emit) begin
            o_left_edge     <= EW'(left_x);
            o_right_edge    <= EW'(right_x);
            o_band_found    <= found;
            o_center_x      <= center;
            o_band_top_y    <= i_top;
            o_band_number   <= i_band_no;
            o_last_band     <= i_retire.last_band;
            o_enough_points <= enough;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== sv/band_column_sum_lane_search_core.sv =====
`timescale 1ns / 1ps
// Lane search over horizontal bands of a binarized region, fed one pixel
// item per clock in raster order when not stalled. The item that closes a
// band is registered in the column-sum stage on acceptance, and its result
// is registered in the output register when it retires: the column sum is
// read from a single column memory on acceptance and added and written back
// on retirement, so the block sustains one pixel per cycle outside stalls,
// with no gaps at row or band ends. The only stall is when a band's last
// pixel reaches the write-back stage while the previous band's result still
// waits in the output register and is not taken in that cycle. One result
// item leaves per band; the frame's last band also carries the enough_points
// flag. After the last band, pixels are dropped until the next frame_start.
// The column memory needs no clearing after reset, since the first row of
// every band overwrites each column.
module band_column_sum_lane_search_core #(
    parameter int MAX_WIDTH       = 512,
    parameter int MAX_BAND_HEIGHT = 64,
    parameter int MAX_BANDS       = 16,
    parameter int MIN_FOUND       = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [bcs_pkg::PIX_W-1:0]            i_pixel,
    input  logic                                 i_frame_start,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [bcs_pkg::EDGE_W-1:0]           o_left_edge,
    output logic signed [bcs_pkg::EDGE_W-1:0]    o_right_edge,
    output logic                                 o_band_found,
    output logic [bcs_pkg::CENTER_W-1:0]         o_center_x,
    output logic [bcs_pkg::TOP_W-1:0]            o_band_top_y,
    output logic [bcs_pkg::BANDNO_W-1:0]         o_band_number,
    output logic                                 o_last_band,
    output logic                                 o_enough_points,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bcs_pkg::APB_AW-1:0]           paddr,
    input  logic [bcs_pkg::APB_DW-1:0]           pwdata,
    output logic [bcs_pkg::APB_DW-1:0]           prdata,
    output logic                                 pready
);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int XW   = (WW > bcs_pkg::ROI_W) ? WW : bcs_pkg::ROI_W;
    localparam int HW   = (MAX_BAND_HEIGHT > 1) ? $clog2(MAX_BAND_HEIGHT) : 1;
    localparam int HW1  = $clog2(MAX_BAND_HEIGHT + 1);
    localparam int HXW  = (HW1 > bcs_pkg::BH_W) ? HW1 : bcs_pkg::BH_W;
    localparam int BW   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int NW1  = $clog2(MAX_BANDS + 1);
    localparam int NXW  = (NW1 > bcs_pkg::NB_W) ? NW1 : bcs_pkg::NB_W;
    localparam int FW   = NW1;
    localparam int DW   = bcs_pkg::APB_DW;

    logic [bcs_pkg::ROI_W-1:0] r_roi_width;
    logic [bcs_pkg::BH_W-1:0]  r_band_height;
    logic [bcs_pkg::NB_W-1:0]  r_num_bands;
    logic [bcs_pkg::THR_W-1:0] r_threshold;

    logic [XW-1:0]  w_eff;
    logic [HXW-1:0] h_eff;
    logic [NXW-1:0] nb_eff;

    bcs_pkg::t_reg_idx  reg_idx;
    logic               cfg_write;
    logic               accept;
    logic               advance;

    bcs_pkg::t_front                front;
    logic [CW-1:0]                  front_col;
    logic [bcs_pkg::TOP_W-1:0]      front_top;
    logic [bcs_pkg::BANDNO_W-1:0]   front_band_no;

    logic                           retire_valid;
    bcs_pkg::t_retire               retire;
    logic [CW-1:0]                  retire_col;
    logic [bcs_pkg::TOP_W-1:0]      retire_top;
    logic [bcs_pkg::BANDNO_W-1:0]   retire_band_no;
    logic                           emit_pending;

    // Configuration registers.
    assign reg_idx   = bcs_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roi_width   <= bcs_pkg::ROI_WIDTH_RST;
            r_band_height <= bcs_pkg::BAND_HEIGHT_RST;
            r_num_bands   <= bcs_pkg::NUM_BANDS_RST;
            r_threshold   <= bcs_pkg::THRESHOLD_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                bcs_pkg::REG_ROI_WIDTH: begin
                    r_roi_width <= pwdata[bcs_pkg::ROI_W-1:0];
                end
                bcs_pkg::REG_BAND_HEIGHT: begin
                    r_band_height <= pwdata[bcs_pkg::BH_W-1:0];
                end
                bcs_pkg::REG_NUM_BANDS: begin
                    r_num_bands <= pwdata[bcs_pkg::NB_W-1:0];
                end
                bcs_pkg::REG_THRESHOLD: begin
                    r_threshold <= pwdata[bcs_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bcs_pkg::REG_ROI_WIDTH:   prdata = DW'(r_roi_width);
            bcs_pkg::REG_BAND_HEIGHT: prdata = DW'(r_band_height);
            bcs_pkg::REG_NUM_BANDS:   prdata = DW'(r_num_bands);
            bcs_pkg::REG_THRESHOLD:   prdata = DW'(r_threshold);
            default:                  prdata = '0;
        endcase
    end

    // Out-of-range register values are clamped to the supported range.
    always_comb begin
        if (XW'(r_roi_width) < XW'(2)) begin
            w_eff = XW'(2);
        end else if (XW'(r_roi_width) > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = XW'(r_roi_width);
        end

        if (r_band_height == '0) begin
            h_eff = HXW'(1);
        end else if (HXW'(r_band_height) > HXW'(MAX_BAND_HEIGHT)) begin
            h_eff = HXW'(MAX_BAND_HEIGHT);
        end else begin
            h_eff = HXW'(r_band_height);
        end

        if (r_num_bands == '0) begin
            nb_eff = NXW'(1);
        end else if (NXW'(r_num_bands) > NXW'(MAX_BANDS)) begin
            nb_eff = NXW'(MAX_BANDS);
        end else begin
            nb_eff = NXW'(r_num_bands);
        end
    end

    // The pipe holds only when a band result cannot be placed.
    assign advance = !(emit_pending && o_valid && !i_ready);
    assign o_ready = advance;
    assign accept  = i_valid && o_ready;

    bcs_ctrl #(
        .CW  (CW),
        .HW  (HW),
        .HXW (HXW),
        .BW  (BW),
        .NXW (NXW),
        .XW  (XW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_frame_start (i_frame_start),
        .i_w_eff       (w_eff),
        .i_h_eff       (h_eff),
        .i_nb_eff      (nb_eff),
        .o_front       (front),
        .o_col         (front_col),
        .o_top         (front_top),
        .o_band_no     (front_band_no)
    );

    bcs_colsum #(
        .DEPTH (MAX_WIDTH),
        .CW    (CW)
    ) u_colsum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_advance      (advance),
        .i_front        (front),
        .i_col          (front_col),
        .i_pixel        (i_pixel),
        .i_top          (front_top),
        .i_band_no      (front_band_no),
        .i_threshold    (r_threshold),
        .o_retire_valid (retire_valid),
        .o_retire       (retire),
        .o_col          (retire_col),
        .o_top          (retire_top),
        .o_band_no      (retire_band_no),
        .o_emit_pending (emit_pending)
    );

    bcs_edges #(
        .CW        (CW),
        .XW        (XW),
        .FW        (FW),
        .MIN_FOUND (MIN_FOUND)
    ) u_edges (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_retire_valid  (retire_valid),
        .i_retire        (retire),
        .i_col           (retire_col),
        .i_top           (retire_top),
        .i_band_no       (retire_band_no),
        .i_w_eff         (w_eff),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_left_edge     (o_left_edge),
        .o_right_edge    (o_right_edge),
        .o_band_found    (o_band_found),
        .o_center_x      (o_center_x),
        .o_band_top_y    (o_band_top_y),
        .o_band_number   (o_band_number),
        .o_last_band     (o_last_band),
        .o_enough_points (o_enough_points)
    );

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without a blocked result");

    a_found_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_band_found) |->
            ($signed({o_right_edge[9], o_right_edge}) > $signed({1'b0, o_left_edge})))
        else $error("band marked found with right edge not past left edge");

    a_center_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_band_found) |-> (o_center_x == '0))
        else $error("center reported for a band without a lane");

    a_enough_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_enough_points) |-> o_last_band)
        else $error("enough_points raised on a band that is not last");

endmodule
